/* hdl/hse_pkg.sv */
// Shared types and command codes for the heap sort engine.
package hse_pkg;

    typedef struct packed {
        logic signed [31:0] value;
        logic               is_last;
    } item_t;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               is_last_res;
    } result_t;

    localparam int OP_W = 4;

    localparam logic [OP_W-1:0] OP_LOAD       = 4'd0;
    localparam logic [OP_W-1:0] OP_SIFT_START = 4'd1;
    localparam logic [OP_W-1:0] OP_SIFT_V     = 4'd2;
    localparam logic [OP_W-1:0] OP_SIFT_L     = 4'd3;
    localparam logic [OP_W-1:0] OP_SIFT_R     = 4'd4;
    localparam logic [OP_W-1:0] OP_SIFT_FIN   = 4'd5;
    localparam logic [OP_W-1:0] OP_NEXT       = 4'd6;
    localparam logic [OP_W-1:0] OP_SORT_RD0   = 4'd7;
    localparam logic [OP_W-1:0] OP_SORT_RDK   = 4'd8;
    localparam logic [OP_W-1:0] OP_EMIT_RD    = 4'd9;
    localparam logic [OP_W-1:0] OP_EMIT_WAIT  = 4'd10;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            sort_phase;
    } cmd_t;

    typedef struct packed {
        logic last_taken;
        logic small_set;
        logic lc_ok;
        logic rc_ok;
        logic child_wins;
        logic nlc_ok;
        logic k_one;
        logic out_free;
        logic emit_last;
    } sts_t;

endpackage

/* hdl/hse_dp.sv */
// Datapath: heap memory, sift registers, counters and the result register.
module hse_dp #(
    parameter int MAX_ITEMS = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  hse_pkg::cmd_t   cmd,
    output hse_pkg::sts_t   sts,
    input  logic            item_valid,
    input  hse_pkg::item_t  item,
    output logic            result_valid,
    input  logic            result_stall,
    output hse_pkg::result_t result
);
    import hse_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int IW = AW + 2;

    logic signed [31:0] heap_mem [MAX_ITEMS];
    logic signed [31:0] rd_data_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] k_reg, k_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] emit_idx_reg, emit_idx_next;
    logic signed [31:0] v_reg, v_next;
    logic signed [31:0] cand_val_reg, cand_val_next;
    logic          cand_child_reg, cand_child_next;
    logic          out_valid_reg, out_valid_next;
    result_t       out_reg, out_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic signed [31:0] wr_data;
    logic [AW-1:0] rd_addr;

    logic          accept;
    logic          full;
    logic [CW-1:0] n_load;
    logic [CW-1:0] limit;
    logic [IW-1:0] limit_ext, lc_idx, rc_idx, nlc_idx;
    logic          lwin, rwin;
    logic          dec_child;
    logic [AW-1:0] dec_idx;
    logic signed [31:0] dec_val;
    logic          out_free;
    logic [CW-1:0] km1;

    always_comb
    begin
        accept    = item_valid && (cmd.op == OP_LOAD);
        full      = (count_reg == CW'(MAX_ITEMS));
        n_load    = full ? count_reg : count_reg + CW'(1);
        limit     = cmd.sort_phase ? k_reg : n_reg;
        limit_ext = IW'(limit);
        lc_idx    = IW'({pos_reg, 1'b1});
        rc_idx    = lc_idx + IW'(1);
        km1       = k_reg - CW'(1);
        lwin      = rd_data_reg > v_reg;
        rwin      = rd_data_reg > cand_val_reg;
        out_free  = !out_valid_reg || !result_stall;

        // Pick the winning child for the node at pos.
        if (cmd.op == OP_SIFT_R)
        begin
            dec_child = rwin || cand_child_reg;
            dec_idx   = rwin ? rc_idx[AW-1:0] : lc_idx[AW-1:0];
            dec_val   = rwin ? rd_data_reg : cand_val_reg;
        end
        else
        begin
            dec_child = lwin;
            dec_idx   = lc_idx[AW-1:0];
            dec_val   = rd_data_reg;
        end
        nlc_idx = IW'({dec_idx, 1'b1});

        sts.last_taken = accept && item.is_last;
        sts.small_set  = (n_load < CW'(2));
        sts.lc_ok      = lc_idx < limit_ext;
        sts.rc_ok      = rc_idx < limit_ext;
        sts.child_wins = dec_child;
        sts.nlc_ok     = nlc_idx < limit_ext;
        sts.k_one      = (k_reg == CW'(1));
        sts.out_free   = out_free;
        sts.emit_last  = (CW'(emit_idx_reg) == n_reg - CW'(1));
    end

    always_comb
    begin
        count_next      = count_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        pos_next        = pos_reg;
        emit_idx_next   = emit_idx_reg;
        v_next          = v_reg;
        cand_val_next   = cand_val_reg;
        cand_child_next = cand_child_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && result_stall;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = v_reg;
        rd_addr         = emit_idx_reg;

        unique case (cmd.op)
            OP_LOAD:
            begin
                emit_idx_next = '0;
                if (accept)
                begin
                    if (!full)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[AW-1:0];
                        wr_data    = item.value;
                        count_next = count_reg + CW'(1);
                    end
                    if (item.is_last)
                    begin
                        n_next = n_load;
                        k_next = n_load >> 1;
                    end
                end
            end
            OP_SIFT_START:
            begin
                rd_addr  = km1[AW-1:0];
                pos_next = km1[AW-1:0];
            end
            OP_SIFT_V:
            begin
                v_next  = rd_data_reg;
                rd_addr = lc_idx[AW-1:0];
                // A node with no child keeps the value; after a swap the root
                // still holds the old top, so write the value back there.
                if (!sts.lc_ok)
                begin
                    wr_en   = 1'b1;
                    wr_data = rd_data_reg;
                end
            end
            OP_SIFT_L, OP_SIFT_R:
            begin
                if (cmd.op == OP_SIFT_L)
                begin
                    cand_val_next   = lwin ? rd_data_reg : v_reg;
                    cand_child_next = lwin;
                end
                if (cmd.op == OP_SIFT_L && sts.rc_ok)
                begin
                    rd_addr = rc_idx[AW-1:0];
                end
                else
                begin
                    // Move the child up, or settle the sifted value here.
                    rd_addr = nlc_idx[AW-1:0];
                    wr_en   = 1'b1;
                    if (dec_child)
                    begin
                        wr_data  = dec_val;
                        pos_next = dec_idx;
                    end
                end
            end
            OP_SIFT_FIN:
            begin
                wr_en = 1'b1;
            end
            OP_NEXT:
            begin
                if (!cmd.sort_phase && sts.k_one)
                begin
                    k_next = n_reg - CW'(1);
                end
                else
                begin
                    k_next = km1;
                end
            end
            OP_SORT_RD0:
            begin
                rd_addr = '0;
            end
            OP_SORT_RDK:
            begin
                wr_en    = 1'b1;
                wr_addr  = k_reg[AW-1:0];
                wr_data  = rd_data_reg;
                rd_addr  = k_reg[AW-1:0];
                pos_next = '0;
            end
            OP_EMIT_RD:
            begin
                rd_addr = emit_idx_reg;
            end
            OP_EMIT_WAIT:
            begin
                rd_addr = emit_idx_reg;
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.sorted_value = rd_data_reg;
                    out_next.is_last_res  = sts.emit_last;
                    emit_idx_next        = emit_idx_reg + AW'(1);
                    if (sts.emit_last)
                    begin
                        count_next = '0;
                    end
                end
            end
            default:
            begin
                rd_addr = emit_idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= heap_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        k_reg          <= k_next;
        pos_reg        <= pos_next;
        emit_idx_reg   <= emit_idx_next;
        v_reg          <= v_next;
        cand_val_reg   <= cand_val_next;
        cand_child_reg <= cand_child_next;
        out_reg        <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

/* hdl/hse_ctrl.sv */
// Controller: sequences loading, heap build, sort-down and emission.
module hse_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  hse_pkg::sts_t sts,
    output hse_pkg::cmd_t cmd,
    output logic          item_stall
);
    import hse_pkg::*;

    localparam logic [3:0] ST_LOAD       = 4'd0;
    localparam logic [3:0] ST_SIFT_START = 4'd1;
    localparam logic [3:0] ST_SIFT_V     = 4'd2;
    localparam logic [3:0] ST_SIFT_L     = 4'd3;
    localparam logic [3:0] ST_SIFT_R     = 4'd4;
    localparam logic [3:0] ST_SIFT_FIN   = 4'd5;
    localparam logic [3:0] ST_NEXT       = 4'd6;
    localparam logic [3:0] ST_SORT_RD0   = 4'd7;
    localparam logic [3:0] ST_SORT_RDK   = 4'd8;
    localparam logic [3:0] ST_EMIT_RD    = 4'd9;
    localparam logic [3:0] ST_EMIT_WAIT  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       phase_reg, phase_next;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (sts.last_taken)
                begin
                    phase_next = 1'b0;
                    state_next = sts.small_set ? ST_EMIT_RD : ST_SIFT_START;
                end
            end
            ST_SIFT_START: state_next = ST_SIFT_V;
            ST_SIFT_V:     state_next = sts.lc_ok ? ST_SIFT_L : ST_NEXT;
            ST_SIFT_L, ST_SIFT_R:
            begin
                priority if (state_reg == ST_SIFT_L && sts.rc_ok)
                    state_next = ST_SIFT_R;
                else if (sts.child_wins)
                    state_next = sts.nlc_ok ? ST_SIFT_L : ST_SIFT_FIN;
                else
                    state_next = ST_NEXT;
            end
            ST_SIFT_FIN:   state_next = ST_NEXT;
            ST_NEXT:
            begin
                if (!phase_reg)
                begin
                    if (sts.k_one)
                    begin
                        phase_next = 1'b1;
                        state_next = ST_SORT_RD0;
                    end
                    else
                    begin
                        state_next = ST_SIFT_START;
                    end
                end
                else
                begin
                    state_next = sts.k_one ? ST_EMIT_RD : ST_SORT_RD0;
                end
            end
            ST_SORT_RD0:   state_next = ST_SORT_RDK;
            ST_SORT_RDK:   state_next = ST_SIFT_V;
            ST_EMIT_RD:    state_next = ST_EMIT_WAIT;
            ST_EMIT_WAIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.emit_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default:       state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            ST_LOAD:       cmd.op = OP_LOAD;
            ST_SIFT_START: cmd.op = OP_SIFT_START;
            ST_SIFT_V:     cmd.op = OP_SIFT_V;
            ST_SIFT_L:     cmd.op = OP_SIFT_L;
            ST_SIFT_R:     cmd.op = OP_SIFT_R;
            ST_SIFT_FIN:   cmd.op = OP_SIFT_FIN;
            ST_NEXT:       cmd.op = OP_NEXT;
            ST_SORT_RD0:   cmd.op = OP_SORT_RD0;
            ST_SORT_RDK:   cmd.op = OP_SORT_RDK;
            ST_EMIT_RD:    cmd.op = OP_EMIT_RD;
            ST_EMIT_WAIT:  cmd.op = OP_EMIT_WAIT;
            default:       cmd.op = OP_EMIT_RD;
        endcase
        cmd.sort_phase = phase_reg;
        item_stall     = (state_reg != ST_LOAD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

/* hdl/heap_sort_engine_top.sv */
// Top level of the heap sort engine: controller plus datapath.
//
//   channel | signals                          | direction | moves
//   --------+----------------------------------+-----------+-------------------------
//   item    | item_valid, item_stall, item     | in        | one value, last flag
//   result  | result_valid, result_stall, result | out     | one sorted value, last flag
//
// Loading accepts a transfer whenever item_valid is high. After the item flagged
// last, the set of n values is sorted in place in a single-port-read heap memory:
// each sift-down level does one memory read per child, and each result is read
// back from memory before it goes out. Reset clears the control state only; the
// heap memory is not cleared. A stalled result holds the engine in emission; the
// item side is stalled from the last transfer until the final result is loaded.
module heap_sort_engine_top #(
    parameter int MAX_ITEMS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  hse_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output hse_pkg::result_t result
);
    import hse_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequence the phases: load, heap build, sort-down, emit.
    hse_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .sts        (sts),
        .cmd        (cmd),
        .item_stall (item_stall)
    );

    // Hold the heap memory, the sift registers and the result register.
    hse_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .item_valid   (item_valid),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the heap sort engine: directed table, then random sets.
`timescale 1ns / 1ps

module tb_top;

    import hse_pkg::*;

    localparam int MAX_ITEMS   = 64;
    localparam int ITEM_GOAL   = 320;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 200;

    // Idle modes, switched by the sender as the run advances
    localparam int MODE_SLOW_RX = 0;
    localparam int MODE_SLOW_TX = 1;
    localparam int MODE_NO_IDLE = 2;

    // Value styles for a random set
    localparam int VAL_FULL    = 0;
    localparam int VAL_TIES    = 1;
    localparam int VAL_EXTREME = 2;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    heap_sort_engine_top #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    // Predictor state
    logic signed [31:0] held_vals [$];
    logic signed [31:0] sort_buf [MAX_ITEMS];
    result_t            pending_sorted [$];

    int n_items;
    int n_sets;
    int n_dropped;
    int largest_set;

    // ------------------------------------------------------------------
    // Clock, cycle count and the run limit
    // ------------------------------------------------------------------
    int unsigned cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("[%0t] timeout after %0d cycles, %0d sorted results still due",
                         $time, cycles, pending_sorted.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sort predictor: collect the set, heapsort it on the last transfer
    // ------------------------------------------------------------------

    // Sift sort_buf[pos] down within positions [0, lim)
    function automatic void heap_settle(int unsigned pos, int unsigned lim);
        int unsigned        top_i;
        int unsigned        lc;
        int unsigned        rc;
        logic signed [31:0] tmp;
        bit                 settled;
        settled = 1'b0;
        while (!settled)
        begin
            top_i = pos;
            lc    = 2 * pos + 1;
            rc    = 2 * pos + 2;
            if (lc < lim && sort_buf[lc] > sort_buf[top_i])
                top_i = lc;
            if (rc < lim && sort_buf[rc] > sort_buf[top_i])
                top_i = rc;
            if (top_i == pos)
                settled = 1'b1;
            else
            begin
                tmp            = sort_buf[pos];
                sort_buf[pos]  = sort_buf[top_i];
                sort_buf[top_i] = tmp;
                pos            = top_i;
            end
        end
    endfunction

    function automatic void heap_sort_buf(int unsigned n);
        int unsigned        k;
        logic signed [31:0] tmp;
        if (n >= 2)
        begin
            // Build the max-heap from the last internal node up to the root
            for (k = (n - 2) / 2 + 1; k > 0; k--)
                heap_settle(k - 1, n);
            // Move the root to the end of the shrinking heap
            for (k = n - 1; k > 0; k--)
            begin
                tmp         = sort_buf[k];
                sort_buf[k] = sort_buf[0];
                sort_buf[0] = tmp;
                heap_settle(0, k);
            end
        end
    endfunction

    // Take one accepted transfer; queue the sorted set when it closes.
    // With predict low the caller queues a typed-in expectation instead.
    function automatic void absorb_item(item_t it, bit predict);
        int n;
        if (held_vals.size() < MAX_ITEMS)
            held_vals.insert(held_vals.size(), it.value);
        else
            n_dropped++;
        n_items++;
        if (it.is_last)
        begin
            n = held_vals.size();
            for (int i = 0; i < n; i++)
                sort_buf[i] = held_vals[i];
            heap_sort_buf(n);
            if (predict)
            begin
                for (int i = 0; i < n; i++)
                    pending_sorted.insert(pending_sorted.size(),
                                          result_t'{sorted_value: sort_buf[i],
                                                    is_last_res: (i == n - 1)});
            end
            if (n > largest_set)
                largest_set = n;
            n_sets++;
            held_vals.delete();
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    int idle_mode;

    function automatic int send_idle_pct();
        case (idle_mode)
            MODE_SLOW_RX: return 12;
            MODE_SLOW_TX: return 63;
            default:      return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct();
        case (idle_mode)
            MODE_SLOW_RX: return 63;
            MODE_SLOW_TX: return 12;
            default:      return 0;
        endcase
    endfunction

    // Offer one item, with random idle cycles first; return at its transfer edge
    task automatic offer_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct())
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_value(int style);
        logic signed [31:0] v;
        case (style)
            VAL_TIES: v = $urandom_range(8) - 4;
            VAL_EXTREME:
            begin
                case ($urandom_range(6))
                    0: v = 32'sh7FFF_FFFF;
                    1: v = 32'sh8000_0000;
                    2: v = 32'sh0000_0000;
                    3: v = 32'shFFFF_FFFF;
                    4: v = 32'sh7FFF_FFFE;
                    5: v = 32'sh8000_0001;
                    default: v = $urandom();
                endcase
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Directed table: the expected result is typed in only for sets of one
    typedef struct packed {
        logic signed [31:0] value;
        logic               is_last;
        logic               typed;
    } dir_row_t;

    localparam int N_DIR = 22;

    dir_row_t dir_rows [N_DIR] = '{
        // sets of one: largest, smallest, zero, minus one
        '{32'sh7FFF_FFFF, 1'b1, 1'b1},
        '{32'sh8000_0000, 1'b1, 1'b1},
        '{32'sh0000_0000, 1'b1, 1'b1},
        '{32'shFFFF_FFFF, 1'b1, 1'b1},
        // pair out of order
        '{32'sd5,         1'b0, 1'b0},
        '{-32'sd5,        1'b1, 1'b0},
        // all equal
        '{32'sd3,         1'b0, 1'b0},
        '{32'sd3,         1'b0, 1'b0},
        '{32'sd3,         1'b1, 1'b0},
        // both ends of the range mixed with zero and minus one
        '{32'sh7FFF_FFFF, 1'b0, 1'b0},
        '{32'sh8000_0000, 1'b0, 1'b0},
        '{32'sh0000_0000, 1'b0, 1'b0},
        '{32'shFFFF_FFFF, 1'b1, 1'b0},
        // descending, then already ascending
        '{32'sd4,         1'b0, 1'b0},
        '{32'sd3,         1'b0, 1'b0},
        '{32'sd2,         1'b0, 1'b0},
        '{32'sd1,         1'b1, 1'b0},
        '{32'sd1,         1'b0, 1'b0},
        '{32'sd2,         1'b0, 1'b0},
        '{32'sd3,         1'b1, 1'b0},
        // alternating bit patterns
        '{32'sh5555_5555, 1'b0, 1'b0},
        '{32'shAAAA_AAAA, 1'b1, 1'b0}
    };

    // ------------------------------------------------------------------
    // Receiver side: check every result transfer, drive result_stall
    // ------------------------------------------------------------------
    int n_results;
    int n_errors;
    int hold_left;
    bit hold_done;

    initial
    begin
        result_t got;
        result_t want;
        bit      took;
        result_stall = 1'b0;
        n_results    = 0;
        n_errors     = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        forever
        begin
            @(posedge clk);
            took = result_valid && !result_stall;
            if (took)
            begin
                got = result;
                n_results++;
                if (pending_sorted.size() == 0)
                begin
                    n_errors++;
                    $display("[%0t] unexpected result: expected none, got value %0d last %0b",
                             $time, got.sorted_value, got.is_last_res);
                end
                else
                begin
                    want = pending_sorted.pop_front();
                    if (got.sorted_value !== want.sorted_value)
                    begin
                        n_errors++;
                        $display("[%0t] sorted_value mismatch: expected %0d, got %0d",
                                 $time, want.sorted_value, got.sorted_value);
                    end
                    if (got.is_last_res !== want.is_last_res)
                    begin
                        n_errors++;
                        $display("[%0t] is_last_res mismatch: expected %0b, got %0b",
                                 $time, want.is_last_res, got.is_last_res);
                    end
                end
            end
            // Hold off once for a long stretch while the sender keeps offering,
            // so the engine backs up into its item side
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else if (idle_mode == MODE_NO_IDLE && !hold_done && took)
            begin
                result_stall <= 1'b1;
                hold_left    = HOLD_CYCLES - 1;
                hold_done    = 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < recv_idle_pct());
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        item_t it;
        int    set_idx;
        int    set_len;
        int    style;
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        item        = '0;
        idle_mode   = MODE_SLOW_RX;
        n_items     = 0;
        n_sets      = 0;
        n_dropped   = 0;
        largest_set = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part
        for (int r = 0; r < N_DIR; r++)
        begin
            it.value   = dir_rows[r].value;
            it.is_last = dir_rows[r].is_last;
            offer_item(it);
            absorb_item(it, !dir_rows[r].typed);
            if (dir_rows[r].typed)
                pending_sorted.insert(pending_sorted.size(),
                                      result_t'{sorted_value: dir_rows[r].value,
                                                is_last_res: 1'b1});
        end

        // Random sets: mostly small, one exactly full, one overflowing
        // (its last-flagged transfer is among the dropped ones), a few large
        set_idx = 0;
        while (n_items < ITEM_GOAL)
        begin
            if (set_idx == 2)
                set_len = MAX_ITEMS;
            else if (set_idx == 5)
                set_len = MAX_ITEMS + $urandom_range(1, 6);
            else if ($urandom_range(19) == 0)
                set_len = $urandom_range(11, MAX_ITEMS);
            else
                set_len = $urandom_range(1, 10);
            style = $urandom_range(2);
            for (int i = 0; i < set_len; i++)
            begin
                // Advance the idle mode by thirds of the run
                if (n_items >= 2 * ITEM_GOAL / 3)
                    idle_mode = MODE_NO_IDLE;
                else if (n_items >= ITEM_GOAL / 3)
                    idle_mode = MODE_SLOW_TX;
                it.value   = ($urandom_range(7) == 0) ? pick_value(VAL_EXTREME)
                                                      : pick_value(style);
                it.is_last = (i == set_len - 1);
                offer_item(it);
                absorb_item(it, 1'b1);
            end
            set_idx++;
        end
        item_valid <= 1'b0;

        // Drain, then give any stray result time to show up
        while (pending_sorted.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d items in %0d sets (largest %0d, %0d dropped on overflow).",
                 n_items, n_sets, largest_set, n_dropped);
        $display("Checked %0d sorted results over three idle modes and one long hold.",
                 n_results);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
